FILE: hdl/tgbe_pkg.sv
package tgbe_pkg;

    localparam int CAPACITY_DEF = 1024;

    // field widths of one command word and one result word
    localparam int CMD_W   = 3;
    localparam int FIELD_W = 11;
    localparam int CHAR_W  = 8;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_MOVE         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE_ONE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE_COUNT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ         = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;    // command word taken this cycle
        logic shift;     // cursor move in progress
        logic res_we;    // load result staging register
        logic res_src;   // 0: result of the command being accepted, 1: finished move/read
        logic out_load;  // staging register to output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic go_shift;  // offered command is a move that shifts bytes
        logic go_resp;   // offered command is a read that hits the text
        logic rem_zero;  // no reads of the move left to issue
    } dp_status_t;

endpackage

FILE: hdl/text_gap_buffer_engine.sv
// Each result passes a staging register, then the output register, before m_tvalid;
// reads wait on the registered store read; moves first copy each byte across the gap.
// Else one command per cycle if output drains; reads and moves block input until staged.
// Reset clears the cursor and gap pointers (empty text) and the handshake state;
// the text store is not cleared and needs no clearing pass.
module text_gap_buffer_engine #(
    parameter int CAPACITY = tgbe_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // command[2:0], position[13:3], character[21:14], count[32:22]
    input  logic [tgbe_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ok[0], char_out[8:1], text_length[19:9], cursor[30:20]
    output logic [tgbe_pkg::M_TDATA_W-1:0] m_tdata
);

    tgbe_pkg::ctrl_cmd_t  cmd;
    tgbe_pkg::dp_status_t st;

    tgbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tgbe_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .st      (st),
        .m_tdata (m_tdata)
    );

endmodule

FILE: hdl/tgbe_ram.sv
module tgbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/tgbe_ctrl.sv
module tgbe_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  tgbe_pkg::dp_status_t  st,
    output tgbe_pkg::ctrl_cmd_t   cmd
);

    tgbe_pkg::state_t state_reg, state_next;
    logic pend_reg, pend_next;
    logic mvalid_reg, mvalid_next;
    logic out_free;
    logic can_finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= tgbe_pkg::ST_IDLE;
            pend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb begin
        out_free     = !mvalid_reg || m_tready;
        cmd          = '0;
        cmd.out_load = pend_reg && out_free;
        // staging slot is free now, or empties this cycle
        can_finish   = !pend_reg || cmd.out_load;
        s_tready     = 1'b0;
        state_next   = state_reg;

        unique case (state_reg)
            tgbe_pkg::ST_IDLE: begin
                s_tready = can_finish;
                if (s_tvalid && can_finish) begin
                    cmd.accept = 1'b1;
                    if (st.go_shift) begin
                        state_next = tgbe_pkg::ST_SHIFT;
                    end else if (st.go_resp) begin
                        state_next = tgbe_pkg::ST_RESP;
                    end else begin
                        cmd.res_we = 1'b1;
                    end
                end
            end
            tgbe_pkg::ST_SHIFT: begin
                cmd.shift = 1'b1;
                // last write goes out in this cycle
                if (st.rem_zero) begin
                    state_next = tgbe_pkg::ST_RESP;
                end
            end
            tgbe_pkg::ST_RESP: begin
                cmd.res_src = 1'b1;
                if (can_finish) begin
                    cmd.res_we = 1'b1;
                    state_next = tgbe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tgbe_pkg::ST_IDLE;
            end
        endcase

        pend_next = cmd.res_we ? 1'b1 : (cmd.out_load ? 1'b0 : pend_reg);
        mvalid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : mvalid_reg);
    end

    assign m_tvalid = mvalid_reg;

endmodule

FILE: hdl/tgbe_datapath.sv
module tgbe_datapath #(
    parameter int CAPACITY = tgbe_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [tgbe_pkg::S_TDATA_W-1:0]    s_tdata,
    input  tgbe_pkg::ctrl_cmd_t               cmd,
    output tgbe_pkg::dp_status_t              st,
    output logic [tgbe_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = (PW > tgbe_pkg::FIELD_W) ? PW : tgbe_pkg::FIELD_W;

    // input word fields
    logic [tgbe_pkg::CMD_W-1:0]   command;
    logic [tgbe_pkg::FIELD_W-1:0] position;
    logic [tgbe_pkg::CHAR_W-1:0]  character;
    logic [tgbe_pkg::FIELD_W-1:0] count;

    assign command   = s_tdata[2:0];
    assign position  = s_tdata[13:3];
    assign character = s_tdata[21:14];
    assign count     = s_tdata[32:22];

    logic [PW-1:0] gs_reg, gs_next;
    logic [PW-1:0] ge_reg, ge_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          dir_reg, dir_next;      // 1: cursor moves right
    logic          rdv_reg, rdv_next;      // RAM data of a move is due this cycle
    logic          rd_flag_reg, rd_flag_next;

    logic                         res_ok_reg;
    logic [tgbe_pkg::CHAR_W-1:0]  res_char_reg;
    logic [tgbe_pkg::FIELD_W-1:0] res_len_reg;
    logic [tgbe_pkg::FIELD_W-1:0] res_cur_reg;
    logic [tgbe_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [PW-1:0] gap;
    logic [PW-1:0] len;
    logic [CW-1:0] pos_w, cnt_w, gs_w, len_w, tgt_w, idx_w, len_simple_w, gs_simple_w;
    logic [PW-1:0] tgt;
    logic          mv_range_ok;
    logic          rd_ok;
    logic          mv_shift;
    logic          mv_right;
    logic [PW-1:0] gs_simple;
    logic          ok_simple;
    logic          ins_we;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tgbe_pkg::CHAR_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [tgbe_pkg::CHAR_W-1:0] ram_rdata;

    assign gap   = ge_reg - gs_reg;
    assign len   = PW'(CAPACITY) - gap;
    assign pos_w = CW'(position);
    assign cnt_w = CW'(count);
    assign gs_w  = CW'(gs_reg);
    assign len_w = CW'(len);

    // decode of the offered command
    always_comb begin
        mv_range_ok = pos_w <= CW'(CAPACITY);
        tgt         = (pos_w > len_w) ? len : PW'(position);
        tgt_w       = CW'(tgt);
        mv_right    = tgt_w > gs_w;
        mv_shift    = (command == tgbe_pkg::CMD_MOVE) && mv_range_ok && (tgt != gs_reg);
        rd_ok       = (command == tgbe_pkg::CMD_READ) && (pos_w < len_w);
        idx_w       = pos_w + ((pos_w >= gs_w) ? CW'(gap) : CW'(0));

        gs_simple = gs_reg;
        ok_simple = 1'b0;
        ins_we    = 1'b0;
        unique case (command)
            tgbe_pkg::CMD_MOVE: begin
                ok_simple = mv_range_ok;
            end
            tgbe_pkg::CMD_INSERT: begin
                if (gs_reg < ge_reg) begin
                    ok_simple = 1'b1;
                    gs_simple = gs_reg + PW'(1);
                    ins_we    = 1'b1;
                end
            end
            tgbe_pkg::CMD_DELETE_ONE: begin
                if (gs_reg != '0) begin
                    ok_simple = 1'b1;
                    gs_simple = gs_reg - PW'(1);
                end
            end
            tgbe_pkg::CMD_DELETE_COUNT: begin
                if (cnt_w <= gs_w) begin
                    ok_simple = 1'b1;
                    gs_simple = gs_reg - PW'(count);
                end
            end
            default: begin
                ok_simple = 1'b0;
            end
        endcase
        len_simple_w = CW'(PW'(CAPACITY) - (ge_reg - gs_simple));
        gs_simple_w  = CW'(gs_simple);
    end

    assign st.go_shift = mv_shift;
    assign st.go_resp  = rd_ok;
    assign st.rem_zero = (rem_reg == '0);

    // gap pointers and move sequencing
    always_comb begin
        gs_next      = gs_reg;
        ge_next      = ge_reg;
        rem_next     = rem_reg;
        rd_ptr_next  = rd_ptr_reg;
        dir_next     = dir_reg;
        rd_flag_next = rd_flag_reg;
        rdv_next     = 1'b0;

        if (cmd.accept) begin
            rd_flag_next = rd_ok;
            if (mv_shift) begin
                dir_next    = mv_right;
                rem_next    = mv_right ? (tgt - gs_reg) : (gs_reg - tgt);
                rd_ptr_next = mv_right ? AW'(ge_reg) : AW'(gs_reg - PW'(1));
            end else if (!rd_ok) begin
                gs_next = gs_simple;
            end
        end

        if (cmd.shift) begin
            if (rem_reg != '0) begin
                rem_next    = rem_reg - PW'(1);
                rd_ptr_next = dir_reg ? (rd_ptr_reg + AW'(1)) : (rd_ptr_reg - AW'(1));
                rdv_next    = 1'b1;
            end
            if (rdv_reg) begin
                gs_next = dir_reg ? (gs_reg + PW'(1)) : (gs_reg - PW'(1));
                ge_next = dir_reg ? (ge_reg + PW'(1)) : (ge_reg - PW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gs_reg      <= '0;
            ge_reg      <= PW'(CAPACITY);
            rem_reg     <= '0;
            rdv_reg     <= 1'b0;
            dir_reg     <= 1'b0;
            rd_flag_reg <= 1'b0;
        end else begin
            gs_reg      <= gs_next;
            ge_reg      <= ge_next;
            rem_reg     <= rem_next;
            rdv_reg     <= rdv_next;
            dir_reg     <= dir_next;
            rd_flag_reg <= rd_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg <= rd_ptr_next;
    end

    // store port use: insert or moved byte on the write side, read or move source on the other
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(gs_reg);
        ram_wdata = character;
        if (cmd.accept && ins_we && !mv_shift && !rd_ok) begin
            ram_we = 1'b1;
        end else if (cmd.shift && rdv_reg) begin
            ram_we    = 1'b1;
            ram_waddr = dir_reg ? AW'(gs_reg) : AW'(ge_reg - PW'(1));
            ram_wdata = ram_rdata;
        end

        ram_re    = 1'b0;
        ram_raddr = rd_ptr_reg;
        if (cmd.accept && rd_ok) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_w);
        end else if (cmd.shift && (rem_reg != '0)) begin
            ram_re = 1'b1;
        end
    end

    tgbe_ram #(
        .WIDTH (tgbe_pkg::CHAR_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result staging and output word
    always_ff @(posedge aclk) begin
        if (cmd.res_we) begin
            if (cmd.res_src) begin
                res_ok_reg   <= 1'b1;
                res_char_reg <= rd_flag_reg ? ram_rdata : '0;
                res_len_reg  <= len_w[tgbe_pkg::FIELD_W-1:0];
                res_cur_reg  <= gs_w[tgbe_pkg::FIELD_W-1:0];
            end else begin
                res_ok_reg   <= ok_simple;
                res_char_reg <= '0;
                res_len_reg  <= len_simple_w[tgbe_pkg::FIELD_W-1:0];
                res_cur_reg  <= gs_simple_w[tgbe_pkg::FIELD_W-1:0];
            end
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {1'b0, res_cur_reg, res_len_reg, res_char_reg, res_ok_reg};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

FILE: hdl/tgbe_checker.sv
module tgbe_checker #(
    parameter int CAPACITY = tgbe_pkg::CAPACITY_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tgbe_pkg::M_TDATA_W-1:0] m_tdata
);

    // 11-bit length and cursor fields wrap at this capacity and above
    localparam bit WRAPS = (CAPACITY >= 2048);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_refused_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
        else $error("refused command returned a byte");

    a_cursor_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> WRAPS || ((m_tdata[30:20] <= m_tdata[19:9])
                    && (32'(m_tdata[19:9]) <= 32'(CAPACITY))))
        else $error("cursor beyond text end or text beyond capacity");

endmodule

bind text_gap_buffer_engine tgbe_checker #(
    .CAPACITY (CAPACITY)
) u_tgbe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/text_gap_buffer_engine_test.sv
`timescale 1ns / 1ps

module text_gap_buffer_engine_test;

    localparam int TEXT_CAP    = tgbe_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int DRAIN_WAIT  = 16;
    localparam int CMW         = tgbe_pkg::CMD_W;
    localparam int FW          = tgbe_pkg::FIELD_W;
    localparam int CHW         = tgbe_pkg::CHAR_W;

    // encodings the block does not define
    localparam logic [CMW-1:0] CMD_SPARE5 = 3'd5;
    localparam logic [CMW-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMW-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic [FW-1:0]  cnt;
        logic [CHW-1:0] ch;
        logic [FW-1:0]  pos;
        logic [CMW-1:0] cmd;
    } edit_cmd_t;

    typedef struct packed {
        logic [FW-1:0]  cur;
        logic [FW-1:0]  len;
        logic [CHW-1:0] chr;
        logic           ok;
    } edit_status_t;

    typedef struct {
        edit_cmd_t    word;
        bit           typed;
        edit_status_t want;
    } plan_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [tgbe_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [tgbe_pkg::M_TDATA_W-1:0] m_tdata;

    text_gap_buffer_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow of the edited text and its cursor
    logic [7:0]   shadow_text[$];
    int unsigned  shadow_cursor = 0;

    edit_status_t awaited_status[$];
    plan_row_t    directed_plan[$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  sink_hold = 0;
    bit           gaps_on = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_gap_buffer_engine_test: errors");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(0, 12);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        edit_status_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(edit_status_t)-1:0];
            if (awaited_status.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: ok=%0d char=%02h len=%0d cur=%0d",
                             got.ok, got.chr, got.len, got.cur);
            end else begin
                want = awaited_status.pop_front();
                if (got.ok !== want.ok || got.chr !== want.chr ||
                        got.len !== want.len || got.cur !== want.cur) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected ok=%0d char=%02h len=%0d cur=%0d,",
                                  " got ok=%0d char=%02h len=%0d cur=%0d"},
                                 want.ok, want.chr, want.len, want.cur,
                                 got.ok, got.chr, got.len, got.cur);
                end
            end
        end
    end

    function automatic edit_status_t predict_edit(edit_cmd_t w);
        edit_status_t r;
        int unsigned  len;
        r   = '0;
        len = shadow_text.size();
        case (w.cmd)
            tgbe_pkg::CMD_MOVE: begin
                if (32'(w.pos) <= TEXT_CAP) begin
                    shadow_cursor = (32'(w.pos) > len) ? len : 32'(w.pos);
                    r.ok = 1'b1;
                end
            end
            tgbe_pkg::CMD_INSERT: begin
                if (len < TEXT_CAP) begin
                    if (shadow_cursor == len)
                        shadow_text.push_back(w.ch);
                    else
                        shadow_text.insert(shadow_cursor, w.ch);
                    shadow_cursor++;
                    r.ok = 1'b1;
                end
            end
            tgbe_pkg::CMD_DELETE_ONE: begin
                if (shadow_cursor > 0) begin
                    shadow_text.delete(shadow_cursor - 1);
                    shadow_cursor--;
                    r.ok = 1'b1;
                end
            end
            tgbe_pkg::CMD_DELETE_COUNT: begin
                if (32'(w.cnt) <= shadow_cursor) begin
                    repeat (w.cnt) begin
                        shadow_text.delete(shadow_cursor - 1);
                        shadow_cursor--;
                    end
                    r.ok = 1'b1;
                end
            end
            tgbe_pkg::CMD_READ: begin
                if (32'(w.pos) < len) begin
                    r.chr = shadow_text[w.pos];
                    r.ok  = 1'b1;
                end
            end
            default: ;
        endcase
        r.len = FW'(shadow_text.size());
        r.cur = FW'(shadow_cursor);
        return r;
    endfunction

    // mostly well-formed edits against the current text, some noise
    function automatic edit_cmd_t random_edit();
        edit_cmd_t   w;
        int unsigned sel, len;
        len   = shadow_text.size();
        w.cmd = CMW'($urandom_range(0, 7));
        w.pos = FW'($urandom_range(0, 2047));
        w.ch  = CHW'($urandom_range(0, 255));
        w.cnt = FW'($urandom_range(0, 2047));
        sel   = $urandom_range(0, 99);
        if (sel < 15) begin
            w.cmd = tgbe_pkg::CMD_MOVE;
            if (sel < 13)
                w.pos = FW'($urandom_range(0, len + 2));
        end else if (sel < 50) begin
            w.cmd = tgbe_pkg::CMD_INSERT;
        end else if (sel < 60) begin
            w.cmd = tgbe_pkg::CMD_DELETE_ONE;
        end else if (sel < 70) begin
            w.cmd = tgbe_pkg::CMD_DELETE_COUNT;
            if (sel < 68)
                w.cnt = FW'($urandom_range(0, (shadow_cursor < 6) ? shadow_cursor + 1 : 6));
        end else if (sel < 95) begin
            w.cmd = tgbe_pkg::CMD_READ;
            if (sel < 92 && len > 0)
                w.pos = FW'($urandom_range(0, len - 1));
        end else begin
            w.cmd = CMW'($urandom_range(CMD_SPARE5, CMD_SPARE7));
        end
        return w;
    endfunction

    function automatic edit_cmd_t make_edit(logic [CMW-1:0] cmd, int unsigned pos,
                                            int unsigned ch, int unsigned cnt);
        edit_cmd_t w;
        w.cmd = cmd;
        w.pos = FW'(pos);
        w.ch  = CHW'(ch);
        w.cnt = FW'(cnt);
        return w;
    endfunction

    function automatic void add_row(edit_cmd_t w, bit typed, bit ok, int unsigned chr,
                                    int unsigned len, int unsigned cur);
        plan_row_t row;
        row.word  = w;
        row.typed = typed;
        row.want  = '{cur: FW'(cur), len: FW'(len), chr: CHW'(chr), ok: ok};
        directed_plan.push_back(row);
    endfunction

    // valid stays high into the next word unless a gap is drawn
    task automatic send_edit(edit_cmd_t w, bit typed, edit_status_t want);
        edit_status_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(tgbe_pkg::S_TDATA_W - $bits(edit_cmd_t)){1'b0}}, w};
        do @(posedge aclk); while (!s_tready);
        r = predict_edit(w);
        awaited_status.push_back(typed ? want : r);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic send_random(int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++) begin
            // the first word keeps the idling mode the caller set
            if (k > 0 && $urandom_range(0, 39) == 0)
                gaps_on <= ($urandom_range(0, 3) != 0);
            send_edit(random_edit(), 1'b0, '0);
        end
    endtask

    initial begin
        edit_cmd_t w;

        // empty text: every refusal and the trivial moves, then inserts and reads on a short text
        add_row(make_edit(tgbe_pkg::CMD_READ, 0, 0, 0),            1'b1, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_DELETE_ONE, 0, 0, 0),      1'b1, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_DELETE_COUNT, 0, 0, 0),    1'b1, 1'b1, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_DELETE_COUNT, 0, 0, 2047), 1'b1, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_MOVE, 0, 0, 0),            1'b1, 1'b1, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_MOVE, 1024, 0, 0),         1'b1, 1'b1, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_MOVE, 1025, 0, 0),         1'b1, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_MOVE, 2047, 255, 2047),    1'b1, 1'b0, 0, 0, 0);
        add_row(make_edit(CMD_SPARE5, 0, 0, 0),                    1'b1, 1'b0, 0, 0, 0);
        add_row(make_edit(CMD_SPARE6, 2047, 255, 2047),            1'b1, 1'b0, 0, 0, 0);
        add_row(make_edit(CMD_SPARE7, 0, 0, 0),                    1'b1, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_INSERT, 0, 8'h00, 0),      1'b1, 1'b1, 0, 1, 1);
        add_row(make_edit(tgbe_pkg::CMD_INSERT, 0, 8'hff, 0),      1'b1, 1'b1, 0, 2, 2);
        add_row(make_edit(tgbe_pkg::CMD_INSERT, 0, 8'ha5, 0),      1'b0, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_INSERT, 0, 8'h5a, 0),      1'b0, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_READ, 0, 0, 0),            1'b1, 1'b1, 8'h00, 4, 4);
        add_row(make_edit(tgbe_pkg::CMD_READ, 3, 0, 0),            1'b1, 1'b1, 8'h5a, 4, 4);
        add_row(make_edit(tgbe_pkg::CMD_READ, 4, 0, 0),            1'b1, 1'b0, 0, 4, 4);
        add_row(make_edit(tgbe_pkg::CMD_READ, 2047, 0, 0),         1'b1, 1'b0, 0, 4, 4);
        // shifting across the gap in both directions
        add_row(make_edit(tgbe_pkg::CMD_MOVE, 0, 0, 0),            1'b0, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_INSERT, 0, 8'h3c, 0),      1'b0, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_MOVE, 2, 0, 0),            1'b0, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_DELETE_ONE, 0, 0, 0),      1'b0, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_DELETE_COUNT, 0, 0, 2047), 1'b0, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_MOVE, 1024, 0, 0),         1'b0, 1'b0, 0, 0, 0);
        add_row(make_edit(tgbe_pkg::CMD_DELETE_COUNT, 0, 0, 1),    1'b0, 1'b0, 0, 0, 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[i])
            send_edit(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].want);

        gaps_on <= 1'b1;
        send_random(300);

        // fill the store completely, with the odd read or move on the way
        while (shadow_text.size() < TEXT_CAP) begin
            w = make_edit(tgbe_pkg::CMD_INSERT, $urandom_range(0, 2047),
                          $urandom_range(0, 255), $urandom_range(0, 2047));
            if ($urandom_range(0, 19) == 0) begin
                w.cmd = $urandom_range(0, 1) ? tgbe_pkg::CMD_READ : tgbe_pkg::CMD_MOVE;
                w.pos = FW'($urandom_range(0, shadow_text.size()));
            end
            send_edit(w, 1'b0, '0);
        end

        // full text: refused inserts, reads at both ends, moves to the extremes
        send_edit(make_edit(tgbe_pkg::CMD_INSERT, 0, 8'h77, 0), 1'b0, '0);
        send_edit(make_edit(tgbe_pkg::CMD_READ, 1023, 0, 0), 1'b0, '0);
        send_edit(make_edit(tgbe_pkg::CMD_READ, 1024, 0, 0), 1'b0, '0);
        send_edit(make_edit(tgbe_pkg::CMD_MOVE, 0, 0, 0), 1'b0, '0);
        send_edit(make_edit(tgbe_pkg::CMD_INSERT, 0, 8'h11, 0), 1'b0, '0);
        send_edit(make_edit(tgbe_pkg::CMD_READ, 0, 0, 0), 1'b0, '0);
        send_edit(make_edit(tgbe_pkg::CMD_MOVE, 512, 0, 0), 1'b0, '0);
        send_edit(make_edit(tgbe_pkg::CMD_MOVE, 1024, 0, 0), 1'b0, '0);
        send_random(40);
        send_edit(make_edit(tgbe_pkg::CMD_MOVE, 1024, 0, 0), 1'b0, '0);
        send_edit(make_edit(tgbe_pkg::CMD_DELETE_COUNT, 0, 0, shadow_cursor), 1'b0, '0);

        send_random(200);
        gaps_on <= 1'b0;
        repeat (100)
            send_edit(random_edit(), 1'b0, '0);
        s_tvalid <= 1'b0;

        while (awaited_status.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatch_count == 0 && awaited_status.size() == 0)
            $display("text_gap_buffer_engine_test: clean");
        else
            $display("text_gap_buffer_engine_test: errors");
        $finish;
    end

endmodule
